>>> hdl/id_number_mod97_validator_core_defines.svh
// Assertion macros for the ID number mod-97 validator.
`ifndef ID_NUMBER_MOD97_VALIDATOR_CORE_DEFINES_SVH
`define ID_NUMBER_MOD97_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IMV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imv assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IMV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imv assertion failed");

`endif

>>> hdl/imv_pkg.sv
// Constants, status codes and mod-97 helper for the ID number validator.
`default_nettype none

package imv_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned RemW    = 7;
  localparam int unsigned KeyW    = 7;
  localparam int unsigned StatusW = 4;

  localparam logic [PosW-1:0] PosMax     = 5'd31;
  localparam logic [PosW-1:0] PosMinLen  = 5'd15;
  localparam logic [PosW-1:0] PosKey     = 5'd13;
  localparam logic [RemW-1:0] Modulus    = 7'd97;
  localparam logic [KeyW-1:0] KeyMax     = 7'd127;

  localparam logic [CharW-1:0] ChNul  = 8'h00;
  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChOne  = 8'h31;
  localparam logic [CharW-1:0] ChTwo  = 8'h32;
  localparam logic [CharW-1:0] ChNine = 8'h39;

  localparam logic [StatusW-1:0] ST_OK     = 4'd0;
  localparam logic [StatusW-1:0] ST_SHORT  = 4'd1;
  localparam logic [StatusW-1:0] ST_SEX    = 4'd2;
  localparam logic [StatusW-1:0] ST_YEAR   = 4'd3;
  localparam logic [StatusW-1:0] ST_MONTH  = 4'd4;
  localparam logic [StatusW-1:0] ST_DEPT   = 4'd5;
  localparam logic [StatusW-1:0] ST_ORDER  = 4'd6;
  localparam logic [StatusW-1:0] ST_DIGIT  = 4'd7;
  localparam logic [StatusW-1:0] ST_KEY    = 4'd8;

  localparam int unsigned F_SEX   = 0;
  localparam int unsigned F_YEAR  = 1;
  localparam int unsigned F_MONTH = 2;
  localparam int unsigned F_DEPT  = 3;
  localparam int unsigned F_ORDER = 4;
  localparam int unsigned F_DIGIT = 5;
  localparam int unsigned FlagW   = 6;

  localparam logic [1:0] MT_ZERO  = 2'd0;
  localparam logic [1:0] MT_ONE   = 2'd1;
  localparam logic [1:0] MT_OTHER = 2'd2;

  // x mod 97 for x < 1024: reciprocal estimate, then one correction.
  function automatic logic [RemW-1:0] mod97(input logic [9:0] x);
    logic [19:0] prod;
    logic [3:0]  q;
    logic [10:0] qm;
    logic [10:0] r;
    prod = {10'd0, x} * 20'd675;
    q    = prod[19:16];
    qm   = {7'd0, q} * 11'd97;
    r    = {1'b0, x} - qm;
    if (r >= 11'd97) r = r - 11'd97;
    return r[RemW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/id_number_mod97_validator_core.sv
// A NUL passes the input register, then its verdict the result register.
// Throughput: one character per cycle; a stalled result holds back only a
// NUL waiting in the input register, and with it the characters behind it.
// Reset (rst, synchronous, active high) clears the input stage, the result
// valid and all string state: position, remainder, key value, flags.
`default_nettype none
`include "id_number_mod97_validator_core_defines.svh"

module id_number_mod97_validator_core
  import imv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [CharW-1:0]   character,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    valid_res,
  output logic [StatusW-1:0]      status,
  output logic [KeyW-1:0]         check_key
);

  logic             in_vld;
  logic [CharW-1:0] in_char;

  logic [PosW-1:0]  position;
  logic [RemW-1:0]  remainder;
  logic [KeyW-1:0]  key_value;
  logic [1:0]       month_tens_class;
  logic [FlagW-1:0] fault_flags;

  logic [PosW-1:0]  position_next;
  logic [RemW-1:0]  remainder_next;
  logic [KeyW-1:0]  key_value_next;
  logic [1:0]       month_tens_class_next;
  logic [FlagW-1:0] fault_flags_next;

  logic             is_nul;
  logic             adv;
  logic             dig;
  logic [3:0]       dval;
  logic [10:0]      key_sum;
  logic [StatusW-1:0] st_calc;
  logic [KeyW-1:0]  exp_calc;

  assign is_nul     = (in_char == ChNul);
  assign adv        = in_vld && (!is_nul || !result_valid || !result_stall);
  assign item_stall = in_vld && !adv;

  assign dig  = (in_char >= ChZero) && (in_char <= ChNine);
  assign dval = dig ? 4'(in_char - ChZero) : 4'd0;
  assign key_sum = {4'd0, key_value} * 11'd10 + {7'd0, dval};
  assign exp_calc = Modulus - remainder;

  always_comb begin
    fault_flags_next      = fault_flags;
    month_tens_class_next = month_tens_class;
    if (position == 5'd0) begin
      if (in_char != ChOne && in_char != ChTwo) fault_flags_next[F_SEX] = 1'b1;
    end else if (position == 5'd1 || position == 5'd2) begin
      if (!dig) fault_flags_next[F_YEAR] = 1'b1;
    end else if (position == 5'd3) begin
      month_tens_class_next = (in_char == ChZero) ? MT_ZERO :
                              (in_char == ChOne)  ? MT_ONE  : MT_OTHER;
    end else if (position == 5'd4) begin
      if (!((month_tens_class == MT_ZERO && in_char >= ChOne && in_char <= ChNine) ||
            (month_tens_class == MT_ONE && in_char >= ChZero && in_char <= ChTwo)))
        fault_flags_next[F_MONTH] = 1'b1;
    end else if (position == 5'd5 || position == 5'd6) begin
      if (!dig) fault_flags_next[F_DEPT] = 1'b1;
    end else if (position >= 5'd10 && position <= PosKey) begin
      if (!dig) fault_flags_next[F_ORDER] = 1'b1;
    end else begin
      if (!dig) fault_flags_next[F_DIGIT] = 1'b1;
    end

    remainder_next = remainder;
    key_value_next = key_value;
    if (position < PosKey) begin
      remainder_next = mod97({3'd0, remainder} * 10'd10 + {6'd0, dval});
    end else begin
      key_value_next = (key_sum > {4'd0, KeyMax}) ? KeyMax : key_sum[KeyW-1:0];
    end

    position_next = (position < PosMax) ? position + 5'd1 : position;
  end

  always_comb begin
    if (position < PosMinLen)             st_calc = ST_SHORT;
    else if (fault_flags[F_SEX])          st_calc = ST_SEX;
    else if (fault_flags[F_YEAR])         st_calc = ST_YEAR;
    else if (fault_flags[F_MONTH])        st_calc = ST_MONTH;
    else if (fault_flags[F_DEPT])         st_calc = ST_DEPT;
    else if (fault_flags[F_ORDER])        st_calc = ST_ORDER;
    else if (fault_flags[F_DIGIT])        st_calc = ST_DIGIT;
    else if (key_value != exp_calc)       st_calc = ST_KEY;
    else                                  st_calc = ST_OK;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!item_stall) begin
      in_vld <= item_valid;
    end
    if (item_valid && !item_stall) in_char <= character;
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= '0;
      remainder        <= '0;
      key_value        <= '0;
      month_tens_class <= MT_ZERO;
      fault_flags      <= '0;
    end else if (adv) begin
      if (is_nul) begin
        position         <= '0;
        remainder        <= '0;
        key_value        <= '0;
        month_tens_class <= MT_ZERO;
        fault_flags      <= '0;
      end else begin
        position         <= position_next;
        remainder        <= remainder_next;
        key_value        <= key_value_next;
        month_tens_class <= month_tens_class_next;
        fault_flags      <= fault_flags_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && is_nul) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (adv && is_nul) begin
      status       <= st_calc;
      valid_res    <= (st_calc == ST_OK);
      check_key    <= (st_calc == ST_SHORT) ? '0 : exp_calc;
    end
  end

  `IMV_ASSERT_IMP(a_valid_res_ok, result_valid, valid_res == (status == ST_OK))
  `IMV_ASSERT_IMP(a_short_no_key, result_valid && status == ST_SHORT, check_key == '0)
  `IMV_ASSERT_NXT(a_nul_clears, adv && is_nul, position == '0 && fault_flags == '0)
  `IMV_ASSERT_IMP(a_rem_range, 1'b1, remainder < Modulus)

endmodule

`default_nettype wire

>>> verif/tb_id_number_mod97_validator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming ID number mod-97 key validator.
module tb_id_number_mod97_validator_core
  import imv_pkg::*;
();

  typedef struct packed {
    logic               ok;
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    key;
  } verdict_t;

  typedef struct {
    logic [CharW-1:0] ch;
    bit               typed;
    verdict_t         want;
  } script_row_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  localparam int unsigned RandomChars = 1750;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned ScriptLen   = 23;

  localparam verdict_t NoVerdict    = '0;
  localparam verdict_t ShortVerdict = '{ok: 1'b0, status: ST_SHORT, key: '0};

  logic               clk;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  logic [CharW-1:0]   character    = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               valid_res;
  logic [StatusW-1:0] status;
  logic [KeyW-1:0]    check_key;

  verdict_t    pending[$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int unsigned stall_left  = 0;

  // Running state of the number being checked.
  logic [PosW-1:0]  nir_pos    = '0;
  logic [RemW-1:0]  nir_rem    = '0;
  logic [KeyW-1:0]  nir_key    = '0;
  logic [1:0]       nir_mclass = MT_ZERO;
  logic [FlagW-1:0] nir_flags  = '0;

  // Short strings, byte extremes, and one well-formed number with key 63.
  script_row_t script [ScriptLen] = '{
    '{ChNul, 1'b1, ShortVerdict},
    '{8'hFF, 1'b0, NoVerdict},
    '{8'h01, 1'b0, NoVerdict},
    '{ChNul, 1'b1, ShortVerdict},
    '{ChOne, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChOne, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{ChZero, 1'b0, NoVerdict},
    '{8'h36, 1'b0, NoVerdict},
    '{8'h33, 1'b0, NoVerdict},
    '{ChNul, 1'b0, NoVerdict},
    '{ChTwo, 1'b0, NoVerdict},
    '{8'h80, 1'b0, NoVerdict},
    '{ChNul, 1'b1, ShortVerdict}
  };

  id_number_mod97_validator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .character    (character),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .valid_res    (valid_res),
    .status       (status),
    .check_key    (check_key)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void nir_clear();
    nir_pos    = '0;
    nir_rem    = '0;
    nir_key    = '0;
    nir_mclass = MT_ZERO;
    nir_flags  = '0;
  endfunction

  // Advances the number state by one character; returns 1 with the verdict on NUL.
  function automatic bit nir_absorb(input logic [CharW-1:0] c, output verdict_t v);
    bit          is_dig;
    int unsigned d;
    int unsigned k;
    is_dig = (c >= ChZero) && (c <= ChNine);
    d      = is_dig ? int'(c - ChZero) : 0;
    v      = '0;
    if (c == ChNul) begin
      if (nir_pos < PosMinLen) v.status = ST_SHORT;
      else if (nir_flags[F_SEX]) v.status = ST_SEX;
      else if (nir_flags[F_YEAR]) v.status = ST_YEAR;
      else if (nir_flags[F_MONTH]) v.status = ST_MONTH;
      else if (nir_flags[F_DEPT]) v.status = ST_DEPT;
      else if (nir_flags[F_ORDER]) v.status = ST_ORDER;
      else if (nir_flags[F_DIGIT]) v.status = ST_DIGIT;
      else if (nir_key != Modulus - nir_rem) v.status = ST_KEY;
      else v.status = ST_OK;
      v.ok  = (v.status == ST_OK);
      v.key = (v.status == ST_SHORT) ? '0 : Modulus - nir_rem;
      nir_clear();
      return 1'b1;
    end
    if (nir_pos == 0) begin
      if (c != ChOne && c != ChTwo) nir_flags[F_SEX] = 1'b1;
    end else if (nir_pos == 1 || nir_pos == 2) begin
      if (!is_dig) nir_flags[F_YEAR] = 1'b1;
    end else if (nir_pos == 3) begin
      nir_mclass = (c == ChZero) ? MT_ZERO : (c == ChOne) ? MT_ONE : MT_OTHER;
    end else if (nir_pos == 4) begin
      if (!((nir_mclass == MT_ZERO && c >= ChOne && c <= ChNine) ||
            (nir_mclass == MT_ONE && c >= ChZero && c <= ChTwo)))
        nir_flags[F_MONTH] = 1'b1;
    end else if (nir_pos == 5 || nir_pos == 6) begin
      if (!is_dig) nir_flags[F_DEPT] = 1'b1;
    end else if (nir_pos >= 10 && nir_pos <= PosKey) begin
      if (!is_dig) nir_flags[F_ORDER] = 1'b1;
    end else begin
      if (!is_dig) nir_flags[F_DIGIT] = 1'b1;
    end
    if (nir_pos < PosKey) begin
      nir_rem = RemW'((int'(nir_rem) * 10 + d) % int'(Modulus));
    end else begin
      k       = int'(nir_key) * 10 + d;
      nir_key = (k > int'(KeyMax)) ? KeyMax : KeyW'(k);
    end
    if (nir_pos < PosMax) nir_pos = nir_pos + 1'b1;
    return 1'b0;
  endfunction

  task automatic send_char(input logic [CharW-1:0] c, input bit typed, input verdict_t want);
    verdict_t    v;
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end
    item_valid = 1'b1;
    character  = c;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (nir_absorb(c, v)) pending.push_back(typed ? want : v);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_valid = 1'b0;
    while (pending.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed numbers with random content, mixed with corrupted ones and noise.
  task automatic build_number(ref logic [CharW-1:0] s[$]);
    int unsigned pick;
    int unsigned rem;
    int unsigned want_key;
    int unsigned n;
    int unsigned idx;
    int unsigned pad;
    s    = {};
    pick = $urandom_range(0, 99);
    if (pick >= 93) begin
      n = $urandom_range(0, 40);
      repeat (n) s.push_back(CharW'($urandom_range(1, 255)));
      return;
    end
    s.push_back($urandom_range(0, 1) ? ChTwo : ChOne);
    for (int i = 1; i < 13; i++) begin
      if (i == 3) begin
        n = $urandom_range(1, 12);
        s.push_back(CharW'(int'(ChZero) + n / 10));
      end else if (i == 4) begin
        s.push_back(CharW'(int'(ChZero) + n % 10));
      end else begin
        s.push_back(CharW'($urandom_range(ChZero, ChNine)));
      end
    end
    rem = 0;
    foreach (s[i]) rem = (rem * 10 + int'(s[i] - ChZero)) % int'(Modulus);
    want_key = int'(Modulus) - rem;
    if (pick >= 50 && pick < 60) want_key = (want_key + $urandom_range(1, 98)) % 100;
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (pick >= 80 && pick < 85) pad = $urandom_range(5, 20);
    repeat (pad) s.push_back(ChZero);
    s.push_back(CharW'(int'(ChZero) + want_key / 10));
    s.push_back(CharW'(int'(ChZero) + want_key % 10));
    if (pick >= 85 && pick < 88)
      repeat ($urandom_range(1, 18)) s.push_back(CharW'($urandom_range(ChZero, ChNine)));
    if (pick >= 60 && pick < 80) begin
      idx    = $urandom_range(0, s.size() - 1);
      s[idx] = $urandom_range(0, 1) ? CharW'($urandom_range(1, 255))
                                    : CharW'($urandom_range(ChZero, ChNine));
    end
    if (pick >= 88) begin
      n = $urandom_range(0, 14);
      while (s.size() > n) void'(s.pop_back());
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:     result_stall <= 1'b0;
      STALL_RANDOM:   result_stall <= ($urandom_range(0, 99) < 40);
      STALL_PERIODIC: result_stall <= (stall_left % 4 != 0);
      default:        result_stall <= ($urandom_range(0, 9) == 0) ? ~result_stall : result_stall;
    endcase
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with none expected: valid_res %0d status %0d key %0d",
                 $time, valid_res, status, check_key);
      end else begin
        want = pending.pop_front();
        if (valid_res !== want.ok) begin
          mismatches++;
          $display("%0t: valid_res expected %0d actual %0d", $time, want.ok, valid_res);
        end
        if (status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (check_key !== want.key) begin
          mismatches++;
          $display("%0t: check_key expected %0d actual %0d", $time, want.key, check_key);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("id_number_mod97_validator_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [CharW-1:0] str[$];
    int unsigned      sent;
    int unsigned      numbers;
    sent    = 0;
    numbers = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) send_char(script[i].ch, script[i].typed, script[i].want);
    drain_results();

    while (sent < RandomChars) begin
      build_number(str);
      str.push_back(ChNul);
      foreach (str[i]) send_char(str[i], 1'b0, NoVerdict);
      sent += str.size();
      numbers++;
      if (numbers % 25 == 0) drain_results();
    end

    item_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("id_number_mod97_validator_core: match");
    end else begin
      $display("id_number_mod97_validator_core: mismatch");
    end
    $finish;
  end

endmodule
